// ===== rtl/u2r_pkg.sv =====
package u2r_pkg;

  // Chroma contribution width: every product below fits a 16-bit signed word.
  localparam int unsigned ChromaW = 16;
  // Channel sum width before clamping.
  localparam int unsigned SumW    = 18;

  // Fixed-point coefficients with 7 fraction bits.
  localparam logic signed [ChromaW-1:0] CoefRedCr   = 16'sd202;
  localparam logic signed [ChromaW-1:0] CoefGreenCb = -16'sd24;
  localparam logic signed [ChromaW-1:0] CoefGreenCr = -16'sd60;
  localparam logic signed [ChromaW-1:0] CoefBlueCb  = 16'sd238;

  // 128*(Y-16) + 64 folds into one offset on the shifted luma.
  localparam logic signed [SumW-1:0] LumaBias = -18'sd1984;

  // Reciprocal multipliers: floor(3r/10) = (615 r) >> 11 and
  // floor(b/5) = (205 b) >> 10, both exact for any 8-bit channel.
  localparam logic [17:0] RedDimMul  = 18'd615;
  localparam logic [15:0] BlueDimMul = 16'd205;

  // Pipeline depth from an accepted word to its result strobe.
  localparam int unsigned Latency = 4;

  // Shared chroma terms handed from the front stage to both pixel lanes.
  typedef struct packed {
    logic signed [ChromaW-1:0] red;
    logic signed [ChromaW-1:0] green;
    logic signed [ChromaW-1:0] blue;
  } chroma_t;

endpackage

// ===== rtl/u2r_pixel_pipe.sv =====
module u2r_pixel_pipe (
  input  logic             clk_i,
  input  logic [7:0]       luma_i,
  input  u2r_pkg::chroma_t chroma_i,
  output logic [15:0]      pixel_o
);
  import u2r_pkg::*;

  logic signed [SumW-1:0] luma_term;
  logic signed [SumW-1:0] sum_r_d, sum_g_d, sum_b_d;
  logic signed [SumW-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [7:0]             red_c, green_c, blue_c;
  logic [17:0]            red_prod_d, red_prod_q;
  logic [15:0]            blue_prod_d, blue_prod_q;
  logic [6:0]             green_dim_d, green_dim_q;
  logic [15:0]            pixel_d, pixel_q;

  // Negative sums go to zero, anything at or above 256 after the shift saturates.
  function automatic logic [7:0] clamp_ch(input logic signed [SumW-1:0] s);
    logic [7:0] v;
    if (s[SumW-1]) begin
      v = 8'd0;
    end else if (s[SumW-2:15] != '0) begin
      v = 8'hff;
    end else begin
      v = s[14:7];
    end
    return v;
  endfunction

  // Stage A: add luma and chroma terms.
  assign luma_term = $signed({3'b000, luma_i, 7'b0000000}) + LumaBias;
  assign sum_r_d   = luma_term + SumW'(chroma_i.red);
  assign sum_g_d   = luma_term + SumW'(chroma_i.green);
  assign sum_b_d   = luma_term + SumW'(chroma_i.blue);

  // Stage B: clamp and start the dimming multiplies.
  assign red_c       = clamp_ch(sum_r_q);
  assign green_c     = clamp_ch(sum_g_q);
  assign blue_c      = clamp_ch(sum_b_q);
  assign red_prod_d  = 18'(red_c) * RedDimMul;
  assign blue_prod_d = 16'(blue_c) * BlueDimMul;
  assign green_dim_d = green_c[7:1];

  // Stage C: finish the reciprocal shifts and keep the top 5/6/5 bits.
  assign pixel_d = {1'b0, red_prod_q[17:14],
                    1'b0, green_dim_q[6:2],
                    2'b00, blue_prod_q[15:13]};

  always_ff @(posedge clk_i) begin
    sum_r_q     <= sum_r_d;
    sum_g_q     <= sum_g_d;
    sum_b_q     <= sum_b_d;
    red_prod_q  <= red_prod_d;
    blue_prod_q <= blue_prod_d;
    green_dim_q <= green_dim_d;
    pixel_q     <= pixel_d;
  end

  assign pixel_o = pixel_q;

endmodule

// ===== rtl/uyvy_to_rgb565_converter_top.sv =====
// UYVY to RGB565 converter. Each word carries one shared Cb byte, one shared
// Cr byte and two luma bytes, and gives two RGB565 pixels with the red channel
// scaled to three tenths, green halved and blue scaled to one fifth. The block
// takes a new word in every clock cycle: busy_o never rises, so start_i may be
// held high for a continuous stream. The result for a word is marked by done_o
// for a single cycle once the word has passed every pipeline stage, and results
// leave in the order the words arrived. There is no back-pressure on the result
// side, so the receiver must take every word in the cycle that done_o is high.
// In the pipeline, one stage forms the shared chroma products, then each pixel
// lane spends one stage on the channel sums, one on clamping and the reciprocal
// multiplies, and one on packing into the output register. The frame-end flag
// travels alongside and comes out with the word it was accepted with.
module uyvy_to_rgb565_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  blue_diff_i,
  input  logic [7:0]  luma_first_i,
  input  logic [7:0]  red_diff_i,
  input  logic [7:0]  luma_second_i,
  input  logic        frame_end_in_i,
  output logic        done_o,
  output logic [15:0] pixel_first_o,
  output logic [15:0] pixel_second_o,
  output logic        frame_end_out_o
);
  import u2r_pkg::*;

  logic signed [7:0]   cb_s, cr_s;
  chroma_t             chroma_d, chroma_q;
  logic [7:0]          luma_first_q, luma_second_q;
  logic [Latency-1:0]  vld_d, vld_q;
  logic [Latency-1:0]  fe_d, fe_q;
  logic                accept;

  // The pipeline never stalls, so a word is always welcome.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Subtracting 128 from an offset-binary byte is the same as flipping its top bit.
  assign cb_s = $signed({~blue_diff_i[7], blue_diff_i[6:0]});
  assign cr_s = $signed({~red_diff_i[7], red_diff_i[6:0]});

  // Front stage: chroma products, shared by both pixels of the word.
  assign chroma_d.red   = ChromaW'(cr_s) * CoefRedCr;
  assign chroma_d.green = ChromaW'(cb_s) * CoefGreenCb + ChromaW'(cr_s) * CoefGreenCr;
  assign chroma_d.blue  = ChromaW'(cb_s) * CoefBlueCb;

  always_ff @(posedge clk_i) begin
    chroma_q      <= chroma_d;
    luma_first_q  <= luma_first_i;
    luma_second_q <= luma_second_i;
  end

  // Valid bits and the frame-end mark follow the data down the pipeline.
  assign vld_d = {vld_q[Latency-2:0], accept};
  assign fe_d  = {fe_q[Latency-2:0], frame_end_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fe_q <= fe_d;
  end

  u2r_pixel_pipe u_first (
    .clk_i    (clk_i),
    .luma_i   (luma_first_q),
    .chroma_i (chroma_q),
    .pixel_o  (pixel_first_o)
  );

  u2r_pixel_pipe u_second (
    .clk_i    (clk_i),
    .luma_i   (luma_second_q),
    .chroma_i (chroma_q),
    .pixel_o  (pixel_second_o)
  );

  assign done_o          = vld_q[Latency-1];
  assign frame_end_out_o = fe_q[Latency-1];

endmodule

// ===== rtl/u2r_checker.sv =====
module u2r_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [7:0]  blue_diff_i,
  input logic [7:0]  luma_first_i,
  input logic [7:0]  red_diff_i,
  input logic [7:0]  luma_second_i,
  input logic        frame_end_in_i,
  input logic        done_o,
  input logic [15:0] pixel_first_o,
  input logic [15:0] pixel_second_o,
  input logic        frame_end_out_o
);

  // A result word is only ever produced for an earlier accepted word.
  a_no_spurious_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result strobe without an accepted word");

  // Every accepted word leaves the pipeline as a result.
  a_no_lost_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start_i && !busy_o, 4) && $past(rst_ni, 1) && $past(rst_ni, 2)
     && $past(rst_ni, 3) && $past(rst_ni, 4)) |-> done_o)
    else $error("accepted word did not produce a result");

  // The frame-end mark leaves with its own word.
  a_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (frame_end_out_o == $past(frame_end_in_i, 4)))
    else $error("frame-end mark out of step with its word");

  // Identical consecutive words give identical pixels.
  a_same_in_same_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o, 1)
     && ($past(blue_diff_i, 4) == $past(blue_diff_i, 5))
     && ($past(red_diff_i, 4) == $past(red_diff_i, 5))
     && ($past(luma_first_i, 4) == $past(luma_first_i, 5))
     && ($past(luma_second_i, 4) == $past(luma_second_i, 5)))
    |-> ((pixel_first_o == $past(pixel_first_o, 1))
         && (pixel_second_o == $past(pixel_second_o, 1))))
    else $error("pixels differ for identical words");

endmodule

bind uyvy_to_rgb565_converter_top u2r_checker u_u2r_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u2r_pkg::Latency;

  // One UYVY word as the sender presents it, and the pixel pair that it must
  // turn into.
  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] y0;
    logic [7:0] cr;
    logic [7:0] y1;
    logic       fe;
  } uyvy_word_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
    logic        fe;
  } rgb_pair_t;

  // A directed row carries its own answer only where the answer is obvious:
  // black at and below the luma floor, neutral white and the all-ones word.
  typedef struct packed {
    uyvy_word_t word;
    logic       typed;
    rgb_pair_t  answer;
  } directed_row_t;

  localparam int unsigned RandomWords  = 850;
  localparam int unsigned IdleLimit    = 500;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned DirectedRows = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  blue_diff_i;
  logic [7:0]  luma_first_i;
  logic [7:0]  red_diff_i;
  logic [7:0]  luma_second_i;
  logic        frame_end_in_i;
  logic        done_o;
  logic [15:0] pixel_first_o;
  logic [15:0] pixel_second_o;
  logic        frame_end_out_o;

  // Pixel pairs still owed by the block, oldest first.
  rgb_pair_t   pending_pixels[$];
  rgb_pair_t   oldest_pair;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;

  directed_row_t directed_rows[DirectedRows] = '{
    // Luma at zero and at the black level with neutral chroma: every channel
    // sum is negative or rounds to nothing, so both pixels are black.
    '{'{8'd128, 8'd0,   8'd128, 8'd16,  1'b0}, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    // Full luma with neutral chroma: grey 239 on each channel, then dimmed.
    '{'{8'd128, 8'd255, 8'd128, 8'd255, 1'b1}, 1'b1, '{16'h43a5, 16'h43a5, 1'b1}},
    // All ones: red and blue saturate at the top before dimming.
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{16'h4a66, 16'h4a66, 1'b1}},
    '{'{8'd0,   8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd128, 8'd0,   8'd64,  1'b0}, 1'b0, '0},
    '{'{8'd0,   8'd200, 8'd255, 8'd30,  1'b1}, 1'b0, '0},
    '{'{8'h55,  8'haa,  8'h55,  8'haa,  1'b1}, 1'b0, '0},
    '{'{8'haa,  8'h55,  8'haa,  8'h55,  1'b0}, 1'b0, '0},
    '{'{8'd127, 8'd235, 8'd129, 8'd16,  1'b0}, 1'b0, '0},
    '{'{8'd129, 8'd1,   8'd127, 8'd254, 1'b1}, 1'b0, '0},
    // Strong red: red clamps high in the second pixel, green goes below zero in the first.
    '{'{8'd128, 8'd0,   8'd255, 8'd128, 1'b0}, 1'b0, '0},
    // No blue at all: the blue sum is negative for most luma values.
    '{'{8'd0,   8'd16,  8'd128, 8'd240, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd200, 8'd128, 8'd100, 1'b1}, 1'b0, '0},
    '{'{8'd16,  8'd81,  8'd240, 8'd145, 1'b1}, 1'b0, '0}
  };

  uyvy_to_rgb565_converter_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .blue_diff_i    (blue_diff_i),
    .luma_first_i   (luma_first_i),
    .red_diff_i     (red_diff_i),
    .luma_second_i  (luma_second_i),
    .frame_end_in_i (frame_end_in_i),
    .done_o         (done_o),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .frame_end_out_o(frame_end_out_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // A channel sum in seven fraction bits is floored to an integer and held
  // within the byte range; a negative sum gives zero outright.
  function automatic int saturate_channel(int sum);
    int level;
    if (sum < 0) begin
      return 0;
    end
    level = sum >>> 7;
    return (level > 255) ? 255 : level;
  endfunction

  // One RGB565 pixel from its luma and the shared chroma. Red is scaled to
  // three tenths, green halved and blue scaled to one fifth, all by floor.
  function automatic logic [15:0] rgb565_of(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    int luma, cbs, crs, red, green, blue;
    luma  = 128 * (int'(y) - 16);
    cbs   = int'(cb) - 128;
    crs   = int'(cr) - 128;
    red   = saturate_channel(luma + 202 * crs + 64) * 3 / 10;
    green = saturate_channel(luma - 24 * cbs - 60 * crs + 64) >> 1;
    blue  = saturate_channel(luma + 238 * cbs + 64) / 5;
    return {red[7:3], green[7:2], blue[7:3]};
  endfunction

  function automatic rgb_pair_t convert_word(uyvy_word_t w);
    rgb_pair_t pair;
    pair.first  = rgb565_of(w.y0, w.cb, w.cr);
    pair.second = rgb565_of(w.y1, w.cb, w.cr);
    pair.fe     = w.fe;
    return pair;
  endfunction

  // Bytes lean towards the corners of the range and the nominal video levels
  // a quarter of the time, so that clamping is hit often.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3) != 0) begin
      return 8'($urandom_range(255));
    end
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd16;
      3: return 8'd127;
      4: return 8'd128;
      5: return 8'd235;
      6: return 8'd240;
      default: return 8'd255;
    endcase
  endfunction

  function automatic uyvy_word_t random_word();
    uyvy_word_t w;
    w.cb = pick_byte();
    w.y0 = pick_byte();
    w.cr = pick_byte();
    w.y1 = pick_byte();
    // Frame ends are sparse, as in a real buffer.
    w.fe = ($urandom_range(15) == 0);
    return w;
  endfunction

  // Presents a word and holds it until the block takes it. The block never
  // raises busy, but the loop keeps to the handshake all the same. The
  // expectation is queued at the edge where the word is accepted.
  task automatic send_word(uyvy_word_t w, logic typed, rgb_pair_t answer);
    blue_diff_i    <= w.cb;
    luma_first_i   <= w.y0;
    red_diff_i     <= w.cr;
    luma_second_i  <= w.y1;
    frame_end_in_i <= w.fe;
    start_i        <= 1'b1;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    pending_pixels.push_back(typed ? answer : convert_word(w));
  endtask

  // Lowers start and waits until every owed pixel pair has come back. At
  // least one edge passes, so the next word is driven in a later time step.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what, rgb_pair_t want);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: %s: expected %h/%h/%b, got %h/%h/%b", $realtime, what,
               want.first, want.second, want.fe,
               pixel_first_o, pixel_second_o, frame_end_out_o);
    end
  endtask

  // The receiver cannot hold results off, so every strobe is checked in the
  // cycle it appears, against the oldest expectation. A strobe with nothing
  // owed is a failure in its own right.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", '0);
      end else begin
        oldest_pair = pending_pixels.pop_front();
        if (pixel_first_o !== oldest_pair.first || pixel_second_o !== oldest_pair.second ||
            frame_end_out_o !== oldest_pair.fe) begin
          report_mismatch("pixel mismatch", oldest_pair);
        end
      end
    end
  end

  // Watchdog: any cycle in which a word goes in or a result comes out counts
  // as progress. A long run of cycles with neither means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IdleLimit) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("FAIL uyvy_to_rgb565_converter_top");
      $finish;
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    // Every input is at a known value from time zero; reset is held low and
    // released on a rising edge.
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    blue_diff_i    <= '0;
    luma_first_i   <= '0;
    red_diff_i     <= '0;
    luma_second_i  <= '0;
    frame_end_in_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed words go in back to back, start held high throughout.
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);
    end
    drain_pipeline();

    // Random words in bursts. Roughly a quarter of the bursts run without a
    // gap after them, giving long stretches of full-rate streaming, while the
    // others leave gaps of random length so that idle cycles land on every
    // stage of the pipeline.
    burst_left = 0;
    for (int unsigned n = 0; n < RandomWords; n++) begin
      // Now and then the sender stops until the pipeline is empty.
      if (n != 0 && n % 200 == 0) begin
        drain_pipeline();
      end
      send_word(random_word(), 1'b0, '0);
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 1);
        gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
        if (gap != 0) begin
          start_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end

    // Wait for the last results, then a few more cycles so that any stray
    // strobe after them is still caught.
    drain_pipeline();
    repeat (Latency + 4) @(posedge clk_i);
    mismatch_count += pending_pixels.size();
    if (mismatch_count == 0) begin
      $display("PASS uyvy_to_rgb565_converter_top");
    end else begin
      $display("FAIL uyvy_to_rgb565_converter_top");
    end
    $finish;
  end

endmodule
